>>> rtl/core/ecf_pkg.sv
// ----------------------------------------------------------------------------
// ecf_pkg
// Shared types and codes for the edge capture frame FIFO.
// ----------------------------------------------------------------------------
package ecf_pkg;

  localparam logic [1:0] KIND_EDGE  = 2'd0;
  localparam logic [1:0] KIND_POP   = 2'd1;
  localparam logic [1:0] KIND_FAULT = 2'd2;

  localparam logic [1:0] FLAG_INVALID  = 2'b01;
  localparam logic [1:0] FLAG_OVERFLOW = 2'b10;

  localparam logic [32:0] DELTA_LIMIT_HI = 33'd0;

  // classified command handed from front to back
  typedef struct packed {
    logic [1:0]  kind;
    logic        bad;        // channel or level out of range
    logic [3:0]  chan;
    logic        level;
    logic [63:0] ts;
  } cmd_t;

  typedef struct packed {
    logic        accepted;
    logic        frame_ok;
    logic [31:0] sequence_res;
    logic [1:0]  frame_flags;
    logic [63:0] base_timestamp;
    logic [3:0]  edge_channel;
    logic        edge_level;
    logic [63:0] edge_timestamp;
    logic [5:0]  edge_index;
    logic        last;
    logic [31:0] dropped_count;
    logic        pending;
  } res_t;

endpackage

>>> rtl/core/ecf_front.sv
// ----------------------------------------------------------------------------
// ecf_front
// Accepts input beats, checks channel and level, and queues commands
// for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
module ecf_front #(
  parameter int NUM_CHANNELS = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    in_kind,
  input  logic [7:0]    in_channel,
  input  logic [7:0]    in_level,
  input  logic [63:0]   in_timestamp,
  output logic          q_valid,
  output ecf_pkg::cmd_t q_cmd,
  input  logic          q_pop
);
  import ecf_pkg::*;

  cmd_t       entry_r [2];
  logic       wr_sel_r, wr_sel_nxt;
  logic       rd_sel_r, rd_sel_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       pop;
  cmd_t       cmd_in;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_cmd    = entry_r[rd_sel_r];

  always_comb begin
    cmd_in.kind  = in_kind;
    cmd_in.bad   = (32'(in_channel) >= NUM_CHANNELS) || (in_level[7:1] != 7'd0);
    cmd_in.chan  = in_channel[3:0];
    cmd_in.level = in_level[0];
    cmd_in.ts    = in_timestamp;
  end

  always_comb begin
    wr_sel_nxt = push ? !wr_sel_r : wr_sel_r;
    rd_sel_nxt = pop ? !rd_sel_r : rd_sel_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_sel_r <= 1'b0;
      rd_sel_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_sel_r <= wr_sel_nxt;
      rd_sel_r <= rd_sel_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_sel_r] <= cmd_in;
    end
  end

endmodule

>>> rtl/core/ecf_back.sv
// ----------------------------------------------------------------------------
// ecf_back
// Executes queued commands: edge store and drop accounting, fault marking,
// and frame pops as a scan pass followed by an emit pass over the ring.
// ----------------------------------------------------------------------------
module ecf_back #(
  parameter int FIFO_DEPTH          = 64,
  parameter int MAX_EDGES_PER_FRAME = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  ecf_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output ecf_pkg::res_t out_res
);
  import ecf_pkg::*;

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int OW = $clog2(FIFO_DEPTH + 1);
  localparam int CW = $clog2(MAX_EDGES_PER_FRAME + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [63:0] mem_time [FIFO_DEPTH];
  logic [4:0]  mem_cl   [FIFO_DEPTH];

  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] wslot_r, wslot_nxt;
  logic [AW-1:0] rslot_r, rslot_nxt;
  logic [OW-1:0] occ_r, occ_nxt;
  logic [1:0]    sticky_r, sticky_nxt;
  logic [31:0]   drop_r, drop_nxt;
  logic [31:0]   seq_r, seq_nxt;
  logic [63:0]   prev_time_r, prev_time_nxt;
  logic          prev_valid_r, prev_valid_nxt;

  logic [CW-1:0] want_r, want_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] issue_idx_r, issue_idx_nxt;
  logic [AW-1:0] issue_addr_r, issue_addr_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic [63:0]   rd_time_r;
  logic [4:0]    rd_cl_r;
  logic [63:0]   base_r, base_nxt;
  logic [1:0]    frm_flags_r, frm_flags_nxt;
  logic [31:0]   frm_seq_r, frm_seq_nxt;

  logic          out_valid_r, out_valid_nxt;
  res_t          out_res_r, out_res_nxt;

  logic          out_free;
  logic          wr_en;
  logic          rd_en;
  logic          load;
  logic          load_now;
  logic          finish;
  logic          fail;
  logic          issue;
  logic [CW-1:0] cnt;
  logic [64:0]   diff;
  logic [AW:0]   rsum;
  res_t          res;

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
    slot_inc = (s == AW'(FIFO_DEPTH - 1)) ? '0 : s + 1'b1;
  endfunction

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // delta of the returning entry from the frame base; must fit in 32 bits
  assign diff = {1'b0, rd_time_r} - {1'b0, base_r};
  assign fail = (diff[64:32] != DELTA_LIMIT_HI);

  always_comb begin
    state_nxt      = state_r;
    wslot_nxt      = wslot_r;
    rslot_nxt      = rslot_r;
    occ_nxt        = occ_r;
    sticky_nxt     = sticky_r;
    drop_nxt       = drop_r;
    seq_nxt        = seq_r;
    prev_time_nxt  = prev_time_r;
    prev_valid_nxt = prev_valid_r;
    want_nxt       = want_r;
    count_nxt      = count_r;
    issue_idx_nxt  = issue_idx_r;
    issue_addr_nxt = issue_addr_r;
    rd_idx_nxt     = rd_idx_r;
    rd_vld_nxt     = 1'b0;
    base_nxt       = base_r;
    frm_flags_nxt  = frm_flags_r;
    frm_seq_nxt    = frm_seq_r;
    q_pop          = 1'b0;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    load           = 1'b0;
    load_now       = 1'b0;
    finish         = 1'b0;
    issue          = 1'b0;
    cnt            = want_r;
    rsum           = '0;
    res            = '0;

    case (state_r)
      ST_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          case (q_cmd.kind)
            KIND_EDGE: begin
              load     = 1'b1;
              res.last = 1'b1;
              if (q_cmd.bad || (prev_valid_r && (q_cmd.ts < prev_time_r))) begin
                sticky_nxt = sticky_r | FLAG_INVALID;
                drop_nxt   = drop_r + 32'd1;
              end else if (occ_r == OW'(FIFO_DEPTH)) begin
                sticky_nxt = sticky_r | FLAG_OVERFLOW;
                drop_nxt   = drop_r + 32'd1;
              end else begin
                wr_en          = 1'b1;
                wslot_nxt      = slot_inc(wslot_r);
                occ_nxt        = occ_r + 1'b1;
                prev_time_nxt  = q_cmd.ts;
                prev_valid_nxt = 1'b1;
                res.accepted   = 1'b1;
              end
            end
            KIND_POP: begin
              if (occ_r == '0) begin
                load     = 1'b1;
                res.last = 1'b1;
              end else begin
                want_nxt       = (32'(occ_r) < MAX_EDGES_PER_FRAME) ? CW'(occ_r)
                                                                     : CW'(MAX_EDGES_PER_FRAME);
                issue_addr_nxt = rslot_r;
                issue_idx_nxt  = '0;
                state_nxt      = ST_SCAN;
              end
            end
            KIND_FAULT: begin
              sticky_nxt = sticky_r | FLAG_INVALID;
              load       = 1'b1;
              res.last   = 1'b1;
            end
            default: begin
              load     = 1'b1;
              res.last = 1'b1;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (rd_vld_r) begin
          if (rd_idx_r == '0) begin
            base_nxt = rd_time_r;
            finish   = (want_r == CW'(1));
          end else if (fail) begin
            finish = 1'b1;
            cnt    = rd_idx_r;
          end else begin
            finish = ((rd_idx_r + 1'b1) == want_r);
          end
        end
        issue = (issue_idx_r < want_r) && !finish;
        if (issue) begin
          rd_en          = 1'b1;
          issue_addr_nxt = slot_inc(issue_addr_r);
          issue_idx_nxt  = issue_idx_r + 1'b1;
          rd_idx_nxt     = issue_idx_r;
        end
        rd_vld_nxt = issue;
        if (finish) begin
          // commit the pop now; the emit pass rereads from the old head
          count_nxt      = cnt;
          frm_flags_nxt  = sticky_r | ((cnt != want_r) ? FLAG_INVALID : 2'b00);
          sticky_nxt     = '0;
          frm_seq_nxt    = seq_r;
          seq_nxt        = seq_r + 32'd1;
          rsum           = (AW + 1)'(rslot_r) + (AW + 1)'(cnt);
          if (rsum >= (AW + 1)'(FIFO_DEPTH)) begin
            rsum = rsum - (AW + 1)'(FIFO_DEPTH);
          end
          rslot_nxt      = rsum[AW-1:0];
          occ_nxt        = occ_r - OW'(cnt);
          issue_addr_nxt = rslot_r;
          issue_idx_nxt  = '0;
          state_nxt      = ST_EMIT;
        end
      end

      ST_EMIT: begin
        load_now = rd_vld_r && out_free;
        issue    = (issue_idx_r < count_r) && (!rd_vld_r || load_now);
        if (load_now) begin
          load               = 1'b1;
          res.frame_ok       = 1'b1;
          res.sequence_res   = frm_seq_r;
          res.frame_flags    = frm_flags_r;
          res.base_timestamp = base_r;
          res.edge_channel   = rd_cl_r[3:0];
          res.edge_level     = rd_cl_r[4];
          res.edge_timestamp = rd_time_r;
          res.edge_index     = 6'(rd_idx_r);
          res.last           = ((rd_idx_r + 1'b1) == count_r);
          if (res.last) begin
            state_nxt = ST_IDLE;
          end
        end
        if (issue) begin
          rd_en          = 1'b1;
          issue_addr_nxt = slot_inc(issue_addr_r);
          issue_idx_nxt  = issue_idx_r + 1'b1;
          rd_idx_nxt     = issue_idx_r;
        end
        rd_vld_nxt = issue ? 1'b1 : (load_now ? 1'b0 : rd_vld_r);
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    res.dropped_count = drop_nxt;
    res.pending       = (occ_nxt != '0);

    out_valid_nxt = out_valid_r && out_stall;
    out_res_nxt   = out_res_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      wslot_r      <= '0;
      rslot_r      <= '0;
      occ_r        <= '0;
      sticky_r     <= '0;
      drop_r       <= '0;
      seq_r        <= '0;
      prev_valid_r <= 1'b0;
      rd_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      wslot_r      <= wslot_nxt;
      rslot_r      <= rslot_nxt;
      occ_r        <= occ_nxt;
      sticky_r     <= sticky_nxt;
      drop_r       <= drop_nxt;
      seq_r        <= seq_nxt;
      prev_valid_r <= prev_valid_nxt;
      rd_vld_r     <= rd_vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_time_r  <= prev_time_nxt;
    want_r       <= want_nxt;
    count_r      <= count_nxt;
    issue_idx_r  <= issue_idx_nxt;
    issue_addr_r <= issue_addr_nxt;
    rd_idx_r     <= rd_idx_nxt;
    base_r       <= base_nxt;
    frm_flags_r  <= frm_flags_nxt;
    frm_seq_r    <= frm_seq_nxt;
    out_res_r    <= out_res_nxt;
  end

  // edge ring storage, registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_time[wslot_r] <= q_cmd.ts;
      mem_cl[wslot_r]   <= {q_cmd.level, q_cmd.chan};
    end
    if (rd_en) begin
      rd_time_r <= mem_time[issue_addr_r];
      rd_cl_r   <= mem_cl[issue_addr_r];
    end
  end

endmodule

>>> rtl/core/edge_capture_frame_fifo.sv
// ----------------------------------------------------------------------------
// edge_capture_frame_fifo
// Timestamped edge capture ring FIFO, drained as frames of edges.
// ----------------------------------------------------------------------------
// Input beats (in_valid/in_stall) carry kind, channel, level and timestamp:
// edge capture, frame pop or transport fault. Result beats (out_valid/
// out_stall) carry one result per edge or fault item, and one result per
// emitted edge for a pop (a single frame_ok=0 result when empty); last
// marks the final result of each item.
// Commands go through a two-entry queue into the back end, which handles
// one item at a time. An edge, fault or empty pop passes from its queue
// entry to the result register and leaves the back end idle for the next
// command. A pop first scans the ring through the single read port to find
// where the frame ends, then emits one edge per cycle while out_stall does
// not hold the result register.
// Reset clears pointers, flags, counters and the queue; ring contents are
// not cleared. While out_stall holds a valid result, the result register
// holds and the back end waits to give its next result; the queue keeps
// taking beats until both entries fill, then in_stall rises.
// ----------------------------------------------------------------------------
module edge_capture_frame_fifo #(
  parameter int FIFO_DEPTH          = 64,
  parameter int MAX_EDGES_PER_FRAME = 32,
  parameter int NUM_CHANNELS        = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_channel,
  input  logic [7:0]  in_level,
  input  logic [63:0] in_timestamp,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_accepted,
  output logic        out_frame_ok,
  output logic [31:0] out_sequence_res,
  output logic [1:0]  out_frame_flags,
  output logic [63:0] out_base_timestamp,
  output logic [3:0]  out_edge_channel,
  output logic        out_edge_level,
  output logic [63:0] out_edge_timestamp,
  output logic [5:0]  out_edge_index,
  output logic        out_last,
  output logic [31:0] out_dropped_count,
  output logic        out_pending
);
  import ecf_pkg::*;

  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;
  res_t res;

  ecf_front #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_channel   (in_channel),
    .in_level     (in_level),
    .in_timestamp (in_timestamp),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop)
  );

  ecf_back #(
    .FIFO_DEPTH          (FIFO_DEPTH),
    .MAX_EDGES_PER_FRAME (MAX_EDGES_PER_FRAME)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_accepted       = res.accepted;
  assign out_frame_ok       = res.frame_ok;
  assign out_sequence_res   = res.sequence_res;
  assign out_frame_flags    = res.frame_flags;
  assign out_base_timestamp = res.base_timestamp;
  assign out_edge_channel   = res.edge_channel;
  assign out_edge_level     = res.edge_level;
  assign out_edge_timestamp = res.edge_timestamp;
  assign out_edge_index     = res.edge_index;
  assign out_last           = res.last;
  assign out_dropped_count  = res.dropped_count;
  assign out_pending        = res.pending;

endmodule
